[sv/cspc_pkg.sv]
`timescale 1ns / 1ps
package cspc_pkg;

	localparam int POW_DEPTH = 1024;
	localparam int IDX_W     = $clog2(POW_DEPTH);
	localparam int W_W       = 17;
	localparam int P_W       = 27;
	localparam int SUM_W     = 28;
	localparam int REM_W     = 29;
	localparam int R_W       = 17;
	localparam int P2_W      = 38;
	localparam int PROD_W    = 2 * P_W;
	localparam int IDXP_W    = R_W + IDX_W + 1;
	localparam int Q_DEPTH   = 4;
	localparam int QPTR_W    = $clog2(Q_DEPTH);

	localparam logic [10:0] C1Q = 11'd1214;
	localparam logic [10:0] C2Q = 11'd1344;

	localparam logic [1:0] CLS_NONE   = 2'd0;
	localparam logic [1:0] CLS_SHADOW = 2'd1;
	localparam logic [1:0] CLS_CLOUD  = 2'd2;
	localparam logic [1:0] CLS_THIN   = 2'd3;

	localparam logic [1:0] REG_CLOUD = 2'd0;
	localparam logic [1:0] REG_THIN  = 2'd1;
	localparam logic [1:0] REG_ALPHA = 2'd2;

	localparam logic [7:0] CLOUD_RED = 8'd255;
	localparam logic [7:0] THIN_RED  = 8'd128;
	localparam logic [7:0] SHAD_BLUE = 8'd255;

	localparam logic [15:0] CLOUD_RST = 16'd700;
	localparam logic [15:0] THIN_RST  = 16'd550;
	localparam logic [7:0]  ALPHA_RST = 8'd50;

	typedef struct packed {
		logic [1:0]     cls;
		logic [P_W-1:0] p;
		logic [P_W-1:0] q;
	} q_entry_t;

	typedef struct packed {
		logic vld;
		logic full;
	} q_status_t;

	typedef logic [W_W-1:0] pow_rom_t [POW_DEPTH];

	// floor(2^16 * (i/(D-1))^0.6), exact in integers
	function automatic pow_rom_t build_pow_rom();
		pow_rom_t    rom;
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic [127:0] dm1;
		logic [127:0] iv;
		logic [17:0]  lo;
		logic [17:0]  hi;
		logic [17:0]  mid;
		dm1 = 128'(POW_DEPTH - 1);
		for (int i = 0; i < POW_DEPTH; i++) begin
			lo = 18'd0;
			hi = 18'd65536;
			iv = 128'(i);
			for (int it = 0; it < 18; it++) begin
				if (lo < hi) begin
					mid = (lo + hi + 18'd1) >> 1;
					lhs = 128'(mid);
					lhs = lhs * 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid);
					lhs = lhs * dm1 * dm1 * dm1;
					rhs = (iv * iv * iv) << 80;
					if (lhs <= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 18'd1;
					end
				end
			end
			rom[i] = lo[W_W-1:0];
		end
		return rom;
	endfunction

endpackage

[sv/cspc_front.sv]
`timescale 1ns / 1ps
module cspc_front
	import cspc_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [15:0]     blue_sample,
	input  logic [15:0]     band_a_sample,
	input  logic [15:0]     band_b_sample,
	input  logic [15:0]     cloud_level,
	input  logic [15:0]     thin_cloud_level,
	input  q_status_t       q_stat,
	output logic            push,
	output q_entry_t        entry
);

	logic     vld_s1;
	q_entry_t ent_s1;
	logic     hold;
	logic [1:0] cls_pre;

	assign hold     = vld_s1 && q_stat.full;
	assign in_stall = hold;
	assign push     = vld_s1 && !q_stat.full;
	assign entry    = ent_s1;

	always_comb begin
		if (blue_sample > cloud_level) begin
			cls_pre = CLS_CLOUD;
		end else if (blue_sample > thin_cloud_level) begin
			cls_pre = CLS_THIN;
		end else begin
			cls_pre = CLS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!hold) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && in_valid) begin
			ent_s1.cls <= cls_pre;
			ent_s1.p   <= P_W'(C1Q * band_a_sample);
			ent_s1.q   <= P_W'(C2Q * band_b_sample);
		end
	end

endmodule

[sv/cspc_queue.sv]
`timescale 1ns / 1ps
module cspc_queue
	import cspc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t q_stat
);

	q_entry_t          mem_q [Q_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_pop;

	assign do_pop      = pop && (cnt_q != '0);
	assign head        = mem_q[rd_q];
	assign q_stat.vld  = (cnt_q != '0);
	assign q_stat.full = (cnt_q == (QPTR_W+1)'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[sv/cspc_back.sv]
`timescale 1ns / 1ps
module cspc_back
	import cspc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  q_entry_t    head,
	input  q_status_t   q_stat,
	output logic        pop,
	input  logic [7:0]  overlay_alpha,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  pixel_class,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out
);

	localparam int NDIV = R_W;
	localparam pow_rom_t POW_ROM = build_pow_rom();

	logic ce;

	logic [NDIV+2:0]  vld_s;
	logic [1:0]       cls_s  [NDIV+3];
	logic             nz_s   [NDIV+3];
	logic [P2_W-1:0]  p2_s   [NDIV+3];
	logic [SUM_W-1:0] sum_s  [NDIV+1];
	logic [REM_W-1:0] rem_s  [NDIV+1];
	logic [R_W-1:0]   quo_s  [NDIV+1];
	logic [IDX_W-1:0] idx_s;
	logic [W_W-1:0]   rom_s;

	logic [P_W-1:0]    diff;
	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] p2_full;
	logic [P2_W-1:0]   p2_sat;
	logic [IDXP_W-1:0] idx_full;
	logic [P2_W-1:0]   lhs;
	logic              shadow;
	logic [1:0]        cls_fin;

	logic       vld_q;
	logic [1:0] cls_q;
	logic [7:0] red_q;
	logic [7:0] blue_q;
	logic [7:0] alpha_q;

	assign ce  = !vld_q || !out_stall;
	assign pop = ce;

	// stage 0: difference, sum, square of weighted band a
	assign diff    = (head.p > head.q) ? (head.p - head.q) : (head.q - head.p);
	assign sum     = SUM_W'(head.p) + SUM_W'(head.q);
	assign p2_full = PROD_W'(head.p) * PROD_W'(head.p);
	assign p2_sat  = (p2_full[PROD_W-1:P2_W-1] != '0) ? {P2_W{1'b1}} : p2_full[P2_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (ce) begin
			vld_s <= {vld_s[NDIV+1:0], q_stat.vld};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cls_s[0] <= head.cls;
			nz_s[0]  <= (sum != '0);
			p2_s[0]  <= p2_sat;
			sum_s[0] <= sum;
			rem_s[0] <= REM_W'(diff);
			quo_s[0] <= '0;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [REM_W-1:0] r2;
		logic             take;
		if (k == 0) begin : g_first
			assign r2 = rem_s[k];
		end else begin : g_next
			assign r2 = {rem_s[k][REM_W-2:0], 1'b0};
		end
		assign take = (r2 >= REM_W'(sum_s[k]));
		always_ff @(posedge clk) begin
			if (ce) begin
				cls_s[k+1] <= cls_s[k];
				nz_s[k+1]  <= nz_s[k];
				p2_s[k+1]  <= p2_s[k];
				sum_s[k+1] <= sum_s[k];
				rem_s[k+1] <= take ? (r2 - REM_W'(sum_s[k])) : r2;
				quo_s[k+1] <= {quo_s[k][R_W-2:0], take};
			end
		end
	end

	assign idx_full = (IDXP_W'(quo_s[NDIV]) * IDXP_W'(POW_DEPTH - 1)
		+ IDXP_W'(32768)) >> 16;

	always_ff @(posedge clk) begin
		if (ce) begin
			cls_s[NDIV+1] <= cls_s[NDIV];
			nz_s[NDIV+1]  <= nz_s[NDIV];
			p2_s[NDIV+1]  <= p2_s[NDIV];
			idx_s <= (idx_full > IDXP_W'(POW_DEPTH - 1)) ? IDX_W'(POW_DEPTH - 1)
				: idx_full[IDX_W-1:0];
			cls_s[NDIV+2] <= cls_s[NDIV+1];
			nz_s[NDIV+2]  <= nz_s[NDIV+1];
			p2_s[NDIV+2]  <= p2_s[NDIV+1];
			rom_s <= POW_ROM[idx_s];
		end
	end

	assign lhs    = P2_W'(rom_s) * P2_W'(20) << 16;
	assign shadow = nz_s[NDIV+2] && (lhs > p2_s[NDIV+2]);
	assign cls_fin = (cls_s[NDIV+2] != CLS_NONE) ? cls_s[NDIV+2]
		: (shadow ? CLS_SHADOW : CLS_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ce) begin
			vld_q <= vld_s[NDIV+2];
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			cls_q <= cls_fin;
			case (cls_fin)
				CLS_CLOUD: begin
					red_q   <= CLOUD_RED;
					blue_q  <= 8'd0;
					alpha_q <= overlay_alpha;
				end
				CLS_THIN: begin
					red_q   <= THIN_RED;
					blue_q  <= 8'd0;
					alpha_q <= overlay_alpha;
				end
				CLS_SHADOW: begin
					red_q   <= 8'd0;
					blue_q  <= SHAD_BLUE;
					alpha_q <= overlay_alpha;
				end
				default: begin
					red_q   <= 8'd0;
					blue_q  <= 8'd0;
					alpha_q <= 8'd0;
				end
			endcase
		end
	end

	assign out_valid   = vld_q;
	assign pixel_class = cls_q;
	assign red_out     = red_q;
	assign green_out   = 8'd0;
	assign blue_out    = blue_q;
	assign alpha_out   = alpha_q;

endmodule

[sv/cloud_shadow_pixel_classifier_top.sv]
`timescale 1ns / 1ps
// an input beat reaches the output through the front register, queue, stage 0, divider, index, ROM and output registers
// throughput: one pixel per cycle when nothing stalls, through the 17-stage divider pipeline
// a 4-entry queue sits between the front stage and the divider pipeline
// reset: asynchronous active low, clears all valid state and pointers,
// thresholds return to 700 and 550 and alpha to 50
module cloud_shadow_pixel_classifier_top
	import cspc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] blue_sample,
	input  logic [15:0] band_a_sample,
	input  logic [15:0] band_b_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  pixel_class,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out
);

	logic [15:0] cloud_q;
	logic [15:0] thin_q;
	logic [7:0]  alpha_q;
	logic        push;
	logic        pop;
	q_entry_t    entry;
	q_entry_t    head;
	q_status_t   q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cloud_q <= CLOUD_RST;
			thin_q  <= THIN_RST;
			alpha_q <= ALPHA_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLOUD: cloud_q <= cfg_data;
				REG_THIN:  thin_q  <= cfg_data;
				REG_ALPHA: alpha_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	cspc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.blue_sample, .band_a_sample, .band_b_sample,
		.cloud_level(cloud_q), .thin_cloud_level(thin_q),
		.q_stat, .push, .entry
	);

	cspc_queue u_queue (
		.clk, .arst_n, .push, .entry, .pop, .head, .q_stat
	);

	cspc_back u_back (
		.clk, .arst_n, .head, .q_stat, .pop, .overlay_alpha(alpha_q),
		.out_valid, .out_stall, .pixel_class, .red_out, .green_out,
		.blue_out, .alpha_out
	);

endmodule

[sv/cspc_checker.sv]
`timescale 1ns / 1ps
module cspc_checker
	import cspc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] pixel_class,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic [7:0] alpha_out
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped under stall");

	a_hold_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_class))
		else $error("class changed under stall");

	a_none_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_class == CLS_NONE |->
		alpha_out == 8'd0 && red_out == 8'd0 && blue_out == 8'd0)
		else $error("unclassified pixel not transparent");

	a_cloud_red: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (pixel_class == CLS_CLOUD || pixel_class == CLS_THIN) |->
		red_out != 8'd0 && blue_out == 8'd0 && green_out == 8'd0)
		else $error("cloud color wrong");

	a_shadow_blue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_class == CLS_SHADOW |->
		blue_out == SHAD_BLUE && red_out == 8'd0)
		else $error("shadow color wrong");

endmodule

bind cloud_shadow_pixel_classifier_top cspc_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .pixel_class,
	.red_out, .green_out, .blue_out, .alpha_out
);

[verif/cspc_overlay_check.sv]
`timescale 1ns / 1ps
module cspc_overlay_check
	import cspc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] blue_sample,
	input  logic [15:0] band_a_sample,
	input  logic [15:0] band_b_sample,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  pixel_class,
	input  logic [7:0]  red_out,
	input  logic [7:0]  green_out,
	input  logic [7:0]  blue_out,
	input  logic [7:0]  alpha_out,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [1:0] cls;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} overlay_t;

	localparam int TOP_IDX = POW_DEPTH - 1;

	logic [16:0] root_table [POW_DEPTH];
	logic [15:0] cloud_thr;
	logic [15:0] thin_thr;
	logic [7:0]  alpha_val;
	overlay_t    overlay_due [$];

	// largest w with w^5 * (D-1)^3 <= i^3 * 2^80
	initial begin
		logic [127:0] lhs;
		logic [127:0] rhs;
		logic [127:0] cube;
		int lo;
		int hi;
		int mid;
		cube = 128'(TOP_IDX) * 128'(TOP_IDX) * 128'(TOP_IDX);
		for (int i = 0; i < POW_DEPTH; i++) begin
			lo = 0;
			hi = 65536;
			rhs = (128'(i) * 128'(i) * 128'(i)) << 80;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				lhs = 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * 128'(mid) * cube;
				if (lhs <= rhs) lo = mid;
				else hi = mid - 1;
			end
			root_table[i] = 17'(lo);
		end
	end

	function automatic logic shadow_test(logic [15:0] a, logic [15:0] b);
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] sum;
		logic [63:0] diff;
		logic [63:0] ratio;
		logic [63:0] idx;
		logic [63:0] w;
		p = 64'(C1Q) * 64'(a);
		q = 64'(C2Q) * 64'(b);
		sum = p + q;
		if (sum == 0) return 1'b0;
		diff = (p > q) ? p - q : q - p;
		ratio = (diff << 16) / sum;
		idx = (ratio * TOP_IDX + 64'd32768) >> 16;
		if (idx > TOP_IDX) idx = TOP_IDX;
		w = 64'(root_table[idx]);
		return (64'd20 * w * 64'd65536) > p * p;
	endfunction

	function automatic overlay_t classify_pixel(logic [15:0] bl, logic [15:0] a,
		logic [15:0] b);
		overlay_t o;
		o = '0;
		if (bl > cloud_thr) begin
			o.cls = CLS_CLOUD;
			o.red = CLOUD_RED;
		end else if (bl > thin_thr) begin
			o.cls = CLS_THIN;
			o.red = THIN_RED;
		end else if (shadow_test(a, b)) begin
			o.cls = CLS_SHADOW;
			o.blue = SHAD_BLUE;
		end else begin
			o.cls = CLS_NONE;
		end
		if (o.cls != CLS_NONE) o.alpha = alpha_val;
		return o;
	endfunction

	assign pending = overlay_due.size();

	always @(posedge clk or negedge arst_n) begin
		overlay_t e;
		if (!arst_n) begin
			cloud_thr <= CLOUD_RST;
			thin_thr <= THIN_RST;
			alpha_val <= ALPHA_RST;
			errors = 0;
			overlay_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CLOUD: cloud_thr <= cfg_data;
					REG_THIN: thin_thr <= cfg_data;
					REG_ALPHA: alpha_val <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				overlay_due = {overlay_due, classify_pixel(blue_sample, band_a_sample,
					band_b_sample)};
			if (out_valid && !out_stall) begin
				if (overlay_due.size() == 0) begin
					$error("output beat with nothing expected");
					errors++;
				end else begin
					e = overlay_due.pop_front();
					if (pixel_class !== e.cls) begin
						$error("pixel_class exp %0d got %0d", e.cls, pixel_class);
						errors++;
					end
					if (red_out !== e.red) begin
						$error("red_out exp %0d got %0d", e.red, red_out);
						errors++;
					end
					if (green_out !== e.green) begin
						$error("green_out exp %0d got %0d", e.green, green_out);
						errors++;
					end
					if (blue_out !== e.blue) begin
						$error("blue_out exp %0d got %0d", e.blue, blue_out);
						errors++;
					end
					if (alpha_out !== e.alpha) begin
						$error("alpha_out exp %0d got %0d", e.alpha, alpha_out);
						errors++;
					end
				end
			end
		end
	end

endmodule

[verif/cloud_shadow_pixel_classifier_top_tb.sv]
`timescale 1ns / 1ps
module cloud_shadow_pixel_classifier_top_tb;
	import cspc_pkg::*;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_WAIT = 40;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] blue_sample;
	logic [15:0] band_a_sample;
	logic [15:0] band_b_sample;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  pixel_class;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic [7:0]  alpha_out;
	int          errors;
	int          pending;
	logic        calm;
	int          idle_cycles;
	logic [15:0] cloud_lvl;
	logic [15:0] thin_lvl;

	cloud_shadow_pixel_classifier_top dut (.*);

	cspc_overlay_check checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int gap_len();
		if (calm) return 0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 0;
			5, 6, 7: return $urandom_range(1, 3);
			8: return $urandom_range(4, 10);
			default: return $urandom_range(20, 60);
		endcase
	endfunction

	// sink backpressure
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(0, 6)) @(negedge clk);
		end
	end

	// idle watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_pixel(logic [15:0] bl, logic [15:0] a, logic [15:0] b);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid <= 1'b1;
		blue_sample <= bl;
		band_a_sample <= a;
		band_b_sample <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CLOUD: cloud_lvl = val;
			REG_THIN: thin_lvl = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic random_pixels(int count);
		logic [15:0] bl;
		logic [15:0] a;
		logic [15:0] b;
		logic [15:0] lo_lvl;
		for (int k = 0; k < count; k++) begin
			if (k % 100 == 0) calm = ($urandom_range(0, 3) == 0);
			lo_lvl = (thin_lvl < cloud_lvl) ? thin_lvl : cloud_lvl;
			case ($urandom_range(0, 7))
				0: bl = 16'($urandom());
				1: bl = 16'($urandom_range(0, 2)) + cloud_lvl - 16'd1;
				2: bl = 16'($urandom_range(0, 2)) + thin_lvl - 16'd1;
				default: bl = 16'($urandom_range(0, lo_lvl));
			endcase
			case ($urandom_range(0, 9))
				0: a = 16'd0;
				1, 2: a = 16'($urandom());
				default: a = 16'($urandom_range(0, 300));
			endcase
			case ($urandom_range(0, 5))
				0: b = 16'd0;
				1: b = 16'((32'(a) * 1214) / 1344);
				2, 3: b = 16'($urandom());
				default: b = 16'($urandom_range(0, 600));
			endcase
			send_pixel(bl, a, b);
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CLOUD;
		cfg_data = '0;
		in_valid = 1'b0;
		blue_sample = '0;
		band_a_sample = '0;
		band_b_sample = '0;
		calm = 1'b0;
		idle_cycles = 0;
		cloud_lvl = CLOUD_RST;
		thin_lvl = THIN_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed pixels at reset thresholds
		send_pixel(16'd0, 16'd0, 16'd0);
		send_pixel(16'd0, 16'd0, 16'd1);
		send_pixel(16'd0, 16'd0, 16'hFFFF);
		send_pixel(16'd0, 16'd672, 16'd607);
		send_pixel(16'd0, 16'd1, 16'd0);
		send_pixel(16'd0, 16'd1, 16'd1);
		send_pixel(16'd0, 16'd100, 16'd0);
		send_pixel(16'd0, 16'd200, 16'd10);
		send_pixel(16'd0, 16'd250, 16'd0);
		send_pixel(16'd0, 16'hFFFF, 16'hFFFF);
		send_pixel(16'd0, 16'hFFFF, 16'd0);
		send_pixel(16'd550, 16'd0, 16'd5);
		send_pixel(16'd551, 16'd0, 16'd5);
		send_pixel(16'd700, 16'd0, 16'd0);
		send_pixel(16'd701, 16'd0, 16'd0);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h5555, 16'hAAAA, 16'h5555);
		send_pixel(16'd3, 16'h0055, 16'hAAAA);
		random_pixels(280);
		drain();

		write_reg(REG_CLOUD, 16'hFFFF);
		write_reg(REG_THIN, 16'hFFFF);
		write_reg(REG_ALPHA, 16'd255);
		send_pixel(16'hFFFF, 16'd0, 16'd9);
		random_pixels(280);
		drain();

		write_reg(REG_CLOUD, 16'd0);
		write_reg(REG_THIN, 16'd0);
		write_reg(REG_ALPHA, 16'd1);
		send_pixel(16'd0, 16'd0, 16'd9);
		send_pixel(16'd1, 16'd0, 16'd9);
		random_pixels(280);
		drain();

		// thin level above cloud level, alpha zero, unused index
		write_reg(REG_CLOUD, 16'd500);
		write_reg(REG_THIN, 16'd800);
		write_reg(REG_ALPHA, 16'd0);
		write_reg(REG_SPARE, 16'hFFFF);
		random_pixels(280);
		drain();

		write_reg(REG_CLOUD, 16'($urandom_range(1000, 60000)));
		write_reg(REG_THIN, 16'($urandom_range(100, 900)));
		write_reg(REG_ALPHA, 16'($urandom_range(1, 254)));
		random_pixels(280);
		drain();

		if (errors == 0 && pending == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

endmodule

[files.f]
sv/cspc_pkg.sv
sv/cspc_front.sv
sv/cspc_queue.sv
sv/cspc_back.sv
sv/cloud_shadow_pixel_classifier_top.sv
sv/cspc_checker.sv
verif/cspc_overlay_check.sv
verif/cloud_shadow_pixel_classifier_top_tb.sv
